@@ rtl/bpb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpb_pkg;

   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned DIGIT_COUNT = 8;
   localparam int unsigned BIN_BITS = 28;
   localparam int unsigned STEPS_PER_STAGE = 7;
   localparam int unsigned STAGE_COUNT = BIN_BITS / STEPS_PER_STAGE;

   localparam logic [DATA_BITS-1:0] BCD_MAX_VALUE = 32'd99999999;
   localparam logic [DATA_BITS-1:0] BCD_OVERFLOW = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [DATA_BITS-1:0] bcd;
      logic [BIN_BITS-1:0]  bin;
      logic                 over;
   } bpb_work_type;

   // One shift-and-add-3 step: digits of five or more are corrected, then
   // the next binary bit shifts into the digit field.
   function automatic bpb_work_type dabble_step(input bpb_work_type w);
      bpb_work_type r;
      logic [DATA_BITS-1:0] adj;
      r = w;
      adj = w.bcd;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (w.bcd[d*4 +: 4] >= 4'd5) begin
            adj[d*4 +: 4] = w.bcd[d*4 +: 4] + 4'd3;
         end
      end
      r.bcd = {adj[DATA_BITS-2:0], w.bin[BIN_BITS-1]};
      r.bin = {w.bin[BIN_BITS-2:0], 1'b0};
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bpb_range_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpb_range_stage
   import bpb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [DATA_BITS-1:0] in_value,
   output      logic                 in_ready,
   output      logic                 out_valid,
   output      bpb_work_type         out_data,
   input  wire logic                 out_ready
);

   logic         valid_ff;
   bpb_work_type data_ff;
   bpb_work_type data_in;

   always_comb begin
      data_in.bcd = '0;
      data_in.bin = in_value[BIN_BITS-1:0];
      data_in.over = (in_value > BCD_MAX_VALUE);
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> out_valid)
      else $error("accepted transaction did not reach the range stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("range stage changed while stalled");

   a_over_clean : assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.over |-> out_data.bcd == '0)
      else $error("range stage digit field not cleared");

endmodule

`default_nettype wire

@@ rtl/bpb_dabble_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpb_dabble_stage
   import bpb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire bpb_work_type in_data,
   output      logic         in_ready,
   output      logic         out_valid,
   output      bpb_work_type out_data,
   input  wire logic         out_ready
);

   logic         valid_ff;
   bpb_work_type data_ff;
   bpb_work_type data_in;

   always_comb begin
      data_in = in_data;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
         data_in = dabble_step(data_in);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> out_valid)
      else $error("accepted transaction did not reach the dabble stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("dabble stage changed while stalled");

   a_over_travels : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> out_data.over == $past(in_data.over))
      else $error("out-of-range flag lost in dabble stage");

endmodule

`default_nettype wire

@@ rtl/binary_to_packed_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary to packed BCD converter.
// The req_ channel carries one unsigned 32-bit value per transaction in
// req_tdata. The rsp_ channel returns eight packed BCD digits in rsp_tdata,
// the most significant digit in bits 31..28. A value above 99999999 returns
// 0xFFFFFFFF as an out-of-range mark.
// The converter is a pipeline of five register stages: a range check and
// four shift-and-add-3 stages of seven steps each over the low 28 bits.
// A result passes the range stage register and then the four dabble stage
// registers to rsp_tvalid; one transaction per cycle is accepted while rsp_tready is high.
// Each stage holds its own valid bit, so bubbles collapse: when the receiver
// stalls, the pipeline keeps accepting until every stage is full, and then
// req_tready drops until rsp_tready returns. Nothing is lost or repeated.
// Reset clears all valid bits; no results are pending afterwards.
module binary_to_packed_bcd
   import bpb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [DATA_BITS-1:0] req_tdata,   // [31:0] binary_value
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [DATA_BITS-1:0] rsp_tdata    // [31:0] bcd_value
);

   logic         stage_valid [STAGE_COUNT+1];
   logic         stage_ready [STAGE_COUNT+1];
   bpb_work_type stage_data [STAGE_COUNT+1];
   logic         digits_ok;

   bpb_range_stage u_range (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_value  (req_tdata),
      .in_ready  (req_tready),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0]),
      .out_ready (stage_ready[0])
   );

   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_dabble
      bpb_dabble_stage u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_data   (stage_data[s]),
         .in_ready  (stage_ready[s]),
         .out_valid (stage_valid[s+1]),
         .out_data  (stage_data[s+1]),
         .out_ready (stage_ready[s+1])
      );
   end

   assign stage_ready[STAGE_COUNT] = rsp_tready;
   assign rsp_tvalid = stage_valid[STAGE_COUNT];
   assign rsp_tdata = stage_data[STAGE_COUNT].over ? BCD_OVERFLOW
                                                   : stage_data[STAGE_COUNT].bcd;

   always_comb begin
      digits_ok = 1'b1;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (rsp_tdata[d*4 +: 4] > 4'd9) begin
            digits_ok = 1'b0;
         end
      end
   end

   a_digits_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !stage_data[STAGE_COUNT].over |-> digits_ok)
      else $error("result holds a digit above nine");

   a_over_mark : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && stage_data[STAGE_COUNT].over |-> rsp_tdata == BCD_OVERFLOW)
      else $error("out-of-range result not marked");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending right after reset");

endmodule

`default_nettype wire
